@@ rtl/itoa_pkg.sv @@
// Package for the integer to radix ASCII converter.
// Holds sizes, character constants and the controller/datapath interface types.
// Depends on nothing.
package itoa_pkg;

  localparam int VALUE_WIDTH    = 64;
  localparam int MAX_CHARS      = 64;
  localparam int DIGIT_SLOTS    = 64;
  localparam int BITS_PER_CYCLE = 8;

  localparam int SIGNED_WIDTH = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int DIV_CYCLES   = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
  localparam int PAD_WIDTH    = DIV_CYCLES * BITS_PER_CYCLE;
  localparam int SLOT_AW      = $clog2(DIGIT_SLOTS);
  localparam int CNT_W        = $clog2(DIGIT_SLOTS + 2);
  localparam int DIVC_W       = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam int RADIX_W = 6;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

  localparam logic [ADDR_W-3:0] REG_RADIX = 1'b0;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  localparam logic [CNT_W-1:0] MAX_CHARS_C  = CNT_W'(MAX_CHARS);
  localparam logic [CNT_W-1:0] SLOT_LAST_C  = CNT_W'(DIGIT_SLOTS - 1);
  localparam logic [DIVC_W-1:0] DIV_LAST_C  = DIVC_W'(DIV_CYCLES - 1);

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic sign_out;
    logic rd_issue;
    logic char_out;
  } itoa_cmd_t;

  typedef struct packed {
    logic div_last;
    logic quot_zero;
    logic slots_full;
    logic neg;
    logic out_free;
    logic emit_last;
  } itoa_stat_t;

endpackage

@@ rtl/itoa_dp.sv @@
// Datapath of the integer to radix ASCII converter: magnitude, radix divider,
// digit buffer and output register.
// Depends on itoa_pkg.
module itoa_dp import itoa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  itoa_cmd_t              cmd,
  output itoa_stat_t             st,
  input  logic [RADIX_W-1:0]     radix,
  input  logic                   in_mode,
  input  logic [63:0]            in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_character,
  output logic                   out_last
);

  logic [RADIX_W-1:0]      base_r;
  logic [PAD_WIDTH-1:0]    mag_r;
  logic [PAD_WIDTH-1:0]    mag_nxt;
  logic [RADIX_W-1:0]      rem_r;
  logic [RADIX_W-1:0]      rem_nxt;
  logic [DIVC_W-1:0]       div_cnt_r;
  logic [CNT_W-1:0]        n_r;
  logic [CNT_W-1:0]        e_r;
  logic [CNT_W-1:0]        rd_ptr_r;
  logic                    neg_r;
  logic [7:0]              rd_data_r;
  logic [7:0]              mem [DIGIT_SLOTS];
  logic                    out_valid_r;
  logic [7:0]              out_char_r;
  logic                    out_last_r;

  logic [RADIX_W-1:0]      base_sel;
  logic [SIGNED_WIDTH-1:0] sv;
  logic [SIGNED_WIDTH-1:0] sv_mag;
  logic                    sv_neg;
  logic [PAD_WIDTH-1:0]    load_mag;
  logic [RADIX_W:0]        trial;
  logic                    qbit;
  logic [7:0]              digit_char;
  logic [CNT_W-1:0]        total;
  logic [CNT_W-1:0]        lim;
  logic [CNT_W-1:0]        rd_idx;

  always_comb begin
    if (radix < RADIX_MIN) begin
      base_sel = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_sel = RADIX_MAX;
    end else begin
      base_sel = radix;
    end
  end

  assign sv     = in_value[SIGNED_WIDTH-1:0];
  assign sv_neg = sv[SIGNED_WIDTH-1];
  assign sv_mag = sv_neg ? SIGNED_WIDTH'(~sv + 1'b1) : sv;

  always_comb begin
    if (in_mode) begin
      load_mag = PAD_WIDTH'(in_value[VALUE_WIDTH-1:0]);
    end else begin
      load_mag = PAD_WIDTH'(sv_mag);
    end
  end

  // Restoring division, several quotient bits per cycle, most significant first.
  always_comb begin
    rem_nxt = rem_r;
    mag_nxt = mag_r;
    trial   = '0;
    qbit    = 1'b0;
    for (int j = 0; j < BITS_PER_CYCLE; j++) begin
      trial = {rem_nxt, mag_nxt[PAD_WIDTH-1]};
      if (trial >= {1'b0, base_r}) begin
        rem_nxt = RADIX_W'(trial - {1'b0, base_r});
        qbit    = 1'b1;
      end else begin
        rem_nxt = trial[RADIX_W-1:0];
        qbit    = 1'b0;
      end
      mag_nxt = {mag_nxt[PAD_WIDTH-2:0], qbit};
    end
  end

  always_comb begin
    if (rem_r < DEC_DIGITS) begin
      digit_char = CHAR_ZERO + 8'(rem_r);
    end else begin
      digit_char = CHAR_A + 8'(rem_r - DEC_DIGITS);
    end
  end

  assign total  = n_r + CNT_W'(neg_r);
  assign lim    = (total > MAX_CHARS_C) ? MAX_CHARS_C : total;
  assign rd_idx = rd_ptr_r - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r    <= base_sel;
      mag_r     <= load_mag;
      rem_r     <= '0;
      div_cnt_r <= '0;
      n_r       <= '0;
      e_r       <= '0;
      neg_r     <= !in_mode && sv_neg;
    end else if (cmd.div_step) begin
      mag_r     <= mag_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + 1'b1;
    end else if (cmd.store) begin
      rem_r     <= '0;
      div_cnt_r <= '0;
      n_r       <= n_r + 1'b1;
      rd_ptr_r  <= n_r + 1'b1;
    end else if (cmd.rd_issue) begin
      rd_ptr_r  <= rd_idx;
    end
    if (cmd.sign_out || cmd.char_out) begin
      e_r <= e_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[n_r[SLOT_AW-1:0]] <= digit_char;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_idx[SLOT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sign_out || cmd.char_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sign_out) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= st.emit_last;
    end else if (cmd.char_out) begin
      out_char_r <= rd_data_r;
      out_last_r <= st.emit_last;
    end
  end

  assign st.div_last   = (div_cnt_r == DIV_LAST_C);
  assign st.quot_zero  = (mag_r == '0);
  assign st.slots_full = (n_r == SLOT_LAST_C);
  assign st.neg        = neg_r;
  assign st.out_free   = !out_valid_r || !out_stall;
  assign st.emit_last  = (CNT_W'(e_r + 1'b1) == lim);

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

@@ rtl/itoa_ctrl.sv @@
// Controller of the integer to radix ASCII converter: sequences division,
// digit storage and character output.
// Depends on itoa_pkg.
module itoa_ctrl import itoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  itoa_stat_t st,
  output itoa_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_STORE = 6'b000100,
    S_SIGN  = 6'b001000,
    S_READ  = 6'b010000,
    S_LOAD  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (!st.quot_zero && !st.slots_full) begin
          state_nxt = S_DIV;
        end else if (st.neg) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_SIGN: begin
        if (st.out_free) begin
          cmd.sign_out = 1'b1;
          state_nxt    = st.emit_last ? S_IDLE : S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LOAD;
      end
      S_LOAD: begin
        if (st.out_free) begin
          cmd.char_out = 1'b1;
          state_nxt    = st.emit_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ rtl/integer_to_radix_ascii.sv @@
// Top level of the integer to radix ASCII converter: radix register, controller
// and datapath.
// Depends on itoa_pkg, itoa_ctrl and itoa_dp.
//
//   channel   ports                                  handshake
//   in        in_mode, in_value                      in_valid / in_stall
//   out       out_character, out_last                out_valid / out_stall
//   cfg       psel, penable, pwrite, paddr, pwdata   APB write, pready high
//
// A request is loaded, then each digit takes radix divider steps at eight bits a cycle
// and a store; then an optional minus sign is output, and each digit a buffer read and
// an output load. Reset is synchronous; it clears the controller, the output valid and
// the radix to ten. A stalled output holds the character and pauses the controller
// before it emits the next character.
module integer_to_radix_ascii import itoa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [63:0]         in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_character,
  output logic                out_last,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [RADIX_W-1:0] radix_r;
  itoa_cmd_t          cmd;
  itoa_stat_t         st;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_RADIX) ? DATA_W'(radix_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_RADIX) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  itoa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .radix         (radix_r),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("controller accepted a request without going busy");

  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sign_out || cmd.char_out) |-> st.out_free)
    else $error("character overwrote an untaken output");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_load_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_valid && !in_stall)
    else $error("datapath loaded without an accepted request");

endmodule
